// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the pointer tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while reset is low.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ps2wm_pkg.sv =====
// Shared types, codes and helpers for the PS/2 wheel-mouse pointer tracker.
// No dependencies; used by the front, the back, the top level and the checker.
`timescale 1ns / 1ps

package ps2wm_pkg;

  localparam int COORD_WIDTH_DEFAULT = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int RX_W        = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_X_RANGE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_RANGE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOUCH_MODE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] X_RANGE_RESET = 13'd640;
  localparam logic [CFG_DATA_W-1:0] Y_RANGE_RESET = 13'd480;
  localparam int X_HOME = 320;
  localparam int Y_HOME = 240;

  // Event kinds.
  localparam logic [2:0] EV_MOVE        = 3'd0;
  localparam logic [2:0] EV_WHEEL       = 3'd1;
  localparam logic [2:0] EV_BTN_DOWN    = 3'd2;
  localparam logic [2:0] EV_BTN_UP      = 3'd3;
  localparam logic [2:0] EV_TOUCH_MOVE  = 3'd4;
  localparam logic [2:0] EV_TOUCH_BEGIN = 3'd5;
  localparam logic [2:0] EV_TOUCH_END   = 3'd6;

  // Event slots of one packet, in emission order.
  localparam logic [1:0] SLOT_MOVE  = 2'd0;
  localparam logic [1:0] SLOT_WHEEL = 2'd1;
  localparam logic [1:0] SLOT_DOWN  = 2'd2;
  localparam logic [1:0] SLOT_UP    = 2'd3;

  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  localparam logic [3:0] WHEEL_NEG_ONE_NIB = 4'hf;

  // Decoded packet as handed from the front to the back.
  typedef struct packed {
    logic [3:0]        mask;   // one bit per slot that emits an event
    logic              touch;
    logic [1:0]        dn_id;
    logic [1:0]        up_id;
    logic signed [4:0] wheel;
  } evset_t;

  // Index of the lowest set bit; the top index when none is set below it.
  function automatic logic [1:0] low_idx(input logic [3:0] m);
    logic [1:0] r;
    if (m[0])      r = 2'd0;
    else if (m[1]) r = 2'd1;
    else if (m[2]) r = 2'd2;
    else           r = 2'd3;
    return r;
  endfunction

endpackage

// ===== rtl/ps2wm_fifo.sv =====
// Two-entry queue between the packet decoder and the event sequencer.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module ps2wm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ps2wm_front.sv =====
// Byte grouping, packet decode, position tracking and configuration registers.
// Depends on ps2wm_pkg; feeds ps2wm_fifo.
`timescale 1ns / 1ps

module ps2wm_front #(
  parameter int COORD_WIDTH = ps2wm_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ps2wm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ps2wm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               rx_valid,
  output logic                               rx_ready,
  input  logic [ps2wm_pkg::RX_W-1:0]         rx_byte,
  input  logic                               q_full,
  output logic                               q_push,
  output ps2wm_pkg::evset_t                  q_set,
  output logic [COORD_WIDTH-1:0]             q_x,
  output logic [COORD_WIDTH-1:0]             q_y
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = ps2wm_pkg::CFG_DATA_W;
  localparam int SW   = ((CW > RW) ? CW : RW) + 2;
  localparam int MASK = (1 << CW) - 1;
  localparam logic [CW-1:0] X_START =
    CW'((ps2wm_pkg::X_HOME > MASK) ? MASK : ps2wm_pkg::X_HOME);
  localparam logic [CW-1:0] Y_START =
    CW'((ps2wm_pkg::Y_HOME > MASK) ? MASK : ps2wm_pkg::Y_HOME);

  logic [RW-1:0]   x_range;
  logic [RW-1:0]   y_range;
  logic            touch_mode;
  logic [7:0]      packet_bytes [3];
  logic [1:0]      byte_index;
  logic [2:0]      old_buttons;
  logic [CW-1:0]   x_position;
  logic [CW-1:0]   y_position;

  logic            take;
  logic            packet_done;
  logic [7:0]      hdr;
  logic [2:0]      btn;
  logic [2:0]      down;
  logic [2:0]      up;
  logic signed [9:0] dx;
  logic signed [9:0] dy;
  logic            moved;
  logic [3:0]      nib;
  logic signed [4:0] wheel;
  logic [CW-1:0]   x_position_next;
  logic [CW-1:0]   y_position_next;
  ps2wm_pkg::evset_t set_next;

  // Add a delta and clamp to 0..range-1, with a zero range acting as one
  // and a range beyond the coordinate width capped to it.
  function automatic logic [CW-1:0] move_axis(input logic [CW-1:0] pos,
                                              input logic signed [9:0] d,
                                              input logic [RW-1:0] range);
    logic [SW-1:0]        r;
    logic [SW-1:0]        cap;
    logic signed [SW-1:0] top;
    logic signed [SW-1:0] p;
    logic [CW-1:0]        res;
    cap = SW'(1) << CW;
    r   = (range == '0) ? SW'(1) : SW'(range);
    if (r > cap) r = cap;
    top = $signed(r - SW'(1));
    p   = $signed(SW'(pos)) + SW'(d);
    if (p < 0)        res = '0;
    else if (p > top) res = CW'(top);
    else              res = CW'(p);
    return res;
  endfunction

  // The fourth byte waits while the queue is full; the others never wait.
  assign rx_ready    = (byte_index != 2'd3) || !q_full;
  assign take        = rx_valid && rx_ready;
  assign packet_done = take && (byte_index == 2'd3);

  always_comb begin
    hdr   = packet_bytes[0];
    btn   = hdr[2:0];
    down  = btn & ~old_buttons;
    up    = old_buttons & ~btn;
    dx    = $signed({hdr[4], hdr[4], packet_bytes[1]});
    dy    = -$signed({hdr[5], hdr[5], packet_bytes[2]});
    moved = (dx != '0) || (dy != '0);
    nib   = rx_byte[3:0];
    wheel = (nib == ps2wm_pkg::WHEEL_NEG_ONE_NIB) ? -5'sd1 : $signed({1'b0, nib});

    x_position_next = (dx != '0) ? move_axis(x_position, dx, x_range) : x_position;
    y_position_next = (dy != '0) ? move_axis(y_position, dy, y_range) : y_position;

    set_next.touch = touch_mode;
    set_next.dn_id = ps2wm_pkg::low_idx({1'b0, down});
    set_next.up_id = ps2wm_pkg::low_idx({1'b0, up});
    set_next.wheel = wheel;
    if (touch_mode) begin
      set_next.mask = {1'b0, up[0], down[0], btn[0] && moved};
    end else begin
      set_next.mask = {up != 3'd0, down != 3'd0, wheel != 5'sd0, moved};
    end
  end

  assign q_push = packet_done && (set_next.mask != 4'd0);
  assign q_set  = set_next;
  assign q_x    = x_position_next;
  assign q_y    = y_position_next;

  always_ff @(posedge clk) begin
    if (take && (byte_index != 2'd3)) begin
      packet_bytes[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_range     <= ps2wm_pkg::X_RANGE_RESET;
      y_range     <= ps2wm_pkg::Y_RANGE_RESET;
      touch_mode  <= 1'b0;
      byte_index  <= 2'd0;
      old_buttons <= 3'd0;
      x_position  <= X_START;
      y_position  <= Y_START;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ps2wm_pkg::CFG_X_RANGE:    x_range    <= cfg_data;
          ps2wm_pkg::CFG_Y_RANGE:    y_range    <= cfg_data;
          ps2wm_pkg::CFG_TOUCH_MODE: touch_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (take) byte_index <= byte_index + 2'd1;
      if (packet_done) begin
        old_buttons <= btn;
        x_position  <= x_position_next;
        y_position  <= y_position_next;
      end
    end
  end

endmodule

// ===== rtl/ps2wm_back.sv =====
// Event sequencer: walks the slots of one decoded packet, one event per transfer.
// Depends on ps2wm_pkg; fed by ps2wm_fifo.
`timescale 1ns / 1ps

module ps2wm_back #(
  parameter int COORD_WIDTH = ps2wm_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  ps2wm_pkg::evset_t      q_set,
  input  logic [COORD_WIDTH-1:0] q_x,
  input  logic [COORD_WIDTH-1:0] q_y,
  output logic                   q_pop,
  output logic                   ev_valid,
  input  logic                   ev_ready,
  output logic [2:0]             event_kind,
  output logic [COORD_WIDTH-1:0] x_pos,
  output logic [COORD_WIDTH-1:0] y_pos,
  output logic [1:0]             button_id,
  output logic signed [4:0]      wheel_delta,
  output logic                   last_of_packet
);

  localparam int CW = COORD_WIDTH;

  logic [3:0]        cur_mask;
  ps2wm_pkg::evset_t cur_set;
  logic [CW-1:0]     cur_x;
  logic [CW-1:0]     cur_y;

  logic [1:0]        slot;
  logic [3:0]        rest;
  logic              out_free;
  logic              emit;
  logic [2:0]        kind_next;
  logic [1:0]        btn_next;
  logic signed [4:0] wheel_next;

  assign slot     = ps2wm_pkg::low_idx(cur_mask);
  assign rest     = cur_mask & ~(4'd1 << slot);
  assign out_free = !ev_valid || ev_ready;
  assign emit     = out_free && (cur_mask != 4'd0);
  // The next packet loads in the cycle its predecessor hands over its last event.
  assign q_pop    = q_valid && ((cur_mask == 4'd0) || (emit && (rest == 4'd0)));

  always_comb begin
    kind_next  = ps2wm_pkg::EV_MOVE;
    btn_next   = ps2wm_pkg::BTN_LEFT;
    wheel_next = 5'sd0;
    if (cur_set.touch) begin
      unique case (slot)
        ps2wm_pkg::SLOT_MOVE:  kind_next = ps2wm_pkg::EV_TOUCH_MOVE;
        ps2wm_pkg::SLOT_WHEEL: kind_next = ps2wm_pkg::EV_TOUCH_BEGIN;
        default:               kind_next = ps2wm_pkg::EV_TOUCH_END;
      endcase
    end else begin
      unique case (slot)
        ps2wm_pkg::SLOT_MOVE: kind_next = ps2wm_pkg::EV_MOVE;
        ps2wm_pkg::SLOT_WHEEL: begin
          kind_next  = ps2wm_pkg::EV_WHEEL;
          wheel_next = cur_set.wheel;
        end
        ps2wm_pkg::SLOT_DOWN: begin
          kind_next = ps2wm_pkg::EV_BTN_DOWN;
          btn_next  = cur_set.dn_id;
        end
        default: begin
          kind_next = ps2wm_pkg::EV_BTN_UP;
          btn_next  = cur_set.up_id;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_set <= q_set;
      cur_x   <= q_x;
      cur_y   <= q_y;
    end
    if (emit) begin
      event_kind     <= kind_next;
      x_pos          <= cur_x;
      y_pos          <= cur_y;
      button_id      <= btn_next;
      wheel_delta    <= wheel_next;
      last_of_packet <= (rest == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= 4'd0;
      ev_valid <= 1'b0;
    end else begin
      if (q_pop)     cur_mask <= q_set.mask;
      else if (emit) cur_mask <= rest;
      if (emit)          ev_valid <= 1'b1;
      else if (ev_ready) ev_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ps2_wheel_mouse_pointer_tracker.sv =====
// PS/2 wheel-mouse pointer tracker, top level.
// Instantiates ps2wm_front, ps2wm_fifo and ps2wm_back; uses ps2wm_pkg.
//
// Input stream (s_*): one received PS/2 byte per transfer, in packet order
// header, dx, dy, wheel. Bytes are grouped four at a time by a wrapping
// counter; the header sync bit is not used to resynchronize.
// Output stream (m_*): events of a packet, in order; tlast marks the last
// event of the packet. A packet gives up to four events, none at all when
// nothing moved or changed.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 x range, 1 y range, 2 touch mode); write only while the block is idle.
// Path: the first event of a packet passes the queue entry, the sequencer's
// current-packet register and the output register. Throughput: one byte per
// cycle while the queue has room, and one event per cycle while the receiver
// takes them; the sequencer loads the next packet as it emits the last event.
// A two-packet queue parts the decoder from the sequencer. While the
// receiver stalls, events hold and bytes keep being taken until the queue
// is full; a fourth byte then waits. Reset empties the queue, drops a
// partly received packet, homes the pointer and restores register defaults.
`timescale 1ns / 1ps

module ps2_wheel_mouse_pointer_tracker #(
  parameter int COORD_WIDTH = ps2wm_pkg::COORD_WIDTH_DEFAULT,
  parameter int OUT_W = ((2 * COORD_WIDTH + 10 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ps2wm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ps2wm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // event_kind, x_pos, y_pos, button_id, wheel_delta, zero fill
  output logic [OUT_W-1:0]                  m_tdata,
  output logic                              m_tlast   // last_of_packet
);

  localparam int CW     = COORD_WIDTH;
  localparam int SET_W  = $bits(ps2wm_pkg::evset_t);
  localparam int Q_W    = SET_W + 2 * CW;

  logic              q_push;
  ps2wm_pkg::evset_t f_set;
  logic [CW-1:0]     f_x;
  logic [CW-1:0]     f_y;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [Q_W-1:0]    q_head;
  ps2wm_pkg::evset_t b_set;
  logic [CW-1:0]     b_x;
  logic [CW-1:0]     b_y;

  logic [2:0]        event_kind;
  logic [CW-1:0]     x_pos;
  logic [CW-1:0]     y_pos;
  logic [1:0]        button_id;
  logic signed [4:0] wheel_delta;

  ps2wm_front #(.COORD_WIDTH(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_valid   (s_tvalid),
    .rx_ready   (s_tready),
    .rx_byte    (s_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_set      (f_set),
    .q_x        (f_x),
    .q_y        (f_y)
  );

  ps2wm_fifo #(.WIDTH(Q_W)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_set, f_x, f_y}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign b_set = q_head[Q_W-1 -: SET_W];
  assign b_x   = q_head[2*CW-1 -: CW];
  assign b_y   = q_head[CW-1:0];

  ps2wm_back #(.COORD_WIDTH(CW)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_set          (b_set),
    .q_x            (b_x),
    .q_y            (b_y),
    .q_pop          (q_pop),
    .ev_valid       (m_tvalid),
    .ev_ready       (m_tready),
    .event_kind     (event_kind),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .button_id      (button_id),
    .wheel_delta    (wheel_delta),
    .last_of_packet (m_tlast)
  );

  assign m_tdata = OUT_W'({wheel_delta, button_id, y_pos, x_pos, event_kind});

endmodule

// ===== rtl/ps2wm_checker.sv =====
// Port-level checks of the pointer tracker, bound to its top level.
// Depends on assert_macros.svh and ps2wm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2wm_checker #(
  parameter int COORD_WIDTH = ps2wm_pkg::COORD_WIDTH_DEFAULT,
  parameter int OUT_W = ((2 * COORD_WIDTH + 10 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  localparam int CW = COORD_WIDTH;

  logic [2:0] kind;
  logic [1:0] btn;
  logic [4:0] whl;

  assign kind = m_tdata[2:0];
  assign btn  = m_tdata[2*CW+4 -: 2];
  assign whl  = m_tdata[2*CW+9 -: 5];

  // A stalled transfer keeps its event.
  `CHK_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output event changed while stalled")

  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !m_tvalid, "output valid right after reset")

  `CHK_ASSERT(a_btn_only, clk, rst, m_tvalid && kind != ps2wm_pkg::EV_BTN_DOWN && kind != ps2wm_pkg::EV_BTN_UP |-> btn == ps2wm_pkg::BTN_LEFT, "button id set on a non-button event")

  `CHK_ASSERT(a_wheel, clk, rst, m_tvalid |-> ((kind == ps2wm_pkg::EV_WHEEL) == (whl != 5'd0)), "wheel value does not match the event kind")

  `CHK_ASSERT(a_kind, clk, rst, m_tvalid |-> kind != 3'd7, "undefined event kind")

endmodule

bind ps2_wheel_mouse_pointer_tracker ps2wm_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .OUT_W       (OUT_W)
) u_ps2wm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ps2_wheel_mouse_pointer_tracker: received bytes in,
// pointer and button events out, with a scoreboard that predicts every event.
// Depends on ps2wm_pkg and the tracker RTL only.

typedef struct packed {
  logic [2:0]        kind;
  logic [11:0]       x;
  logic [11:0]       y;
  logic [1:0]        btn;
  logic signed [4:0] wheel;
  logic              last;
} pointer_event_t;

class tracker_scoreboard;
  localparam int CW = ps2wm_pkg::COORD_WIDTH_DEFAULT;
  localparam int unsigned SPAN = 1 << CW;

  int unsigned    x_range;
  int unsigned    y_range;
  bit             touch_mode;
  logic [7:0]     pkt_bytes [3];
  int unsigned    byte_phase;
  logic [2:0]     old_buttons;
  int unsigned    x_pos;
  int unsigned    y_pos;
  pointer_event_t pending_events [$];
  int             errors;

  function new();
    x_range = ps2wm_pkg::X_RANGE_RESET;
    y_range = ps2wm_pkg::Y_RANGE_RESET;
    touch_mode = 1'b0;
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
    byte_phase = 0;
    old_buttons = 3'b000;
    x_pos = (ps2wm_pkg::X_HOME > SPAN - 1) ? SPAN - 1 : ps2wm_pkg::X_HOME;
    y_pos = (ps2wm_pkg::Y_HOME > SPAN - 1) ? SPAN - 1 : ps2wm_pkg::Y_HOME;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] index, logic [12:0] value);
    case (index)
      ps2wm_pkg::CFG_X_RANGE:    x_range = value;
      ps2wm_pkg::CFG_Y_RANGE:    y_range = value;
      ps2wm_pkg::CFG_TOUCH_MODE: touch_mode = value[0];
      default: ;
    endcase
  endfunction

  // A zero range behaves as one, anything beyond the coordinate span as the span.
  function int unsigned move_axis(int unsigned pos, int delta, int unsigned range);
    int top;
    int p;
    if (range == 0) range = 1;
    if (range > SPAN) range = SPAN;
    top = int'(range) - 1;
    p = int'(pos) + delta;
    if (p < 0) p = 0;
    if (p > top) p = top;
    return p;
  endfunction

  function logic [1:0] lowest_button(logic [2:0] m);
    if (m[0]) return ps2wm_pkg::BTN_LEFT;
    if (m[1]) return ps2wm_pkg::BTN_RIGHT;
    return ps2wm_pkg::BTN_MIDDLE;
  endfunction

  // Every fourth byte closes a packet and produces its events.
  function void take_byte(logic [7:0] b);
    logic [7:0]     hdr;
    logic [2:0]     btn;
    logic [2:0]     pressed;
    logic [2:0]     released;
    logic [3:0]     nib;
    int             dx;
    int             dy;
    int             wheel;
    bit             moved;
    logic [2:0]     kinds [4];
    logic [1:0]     ids [4];
    int             wheels [4];
    int             n;
    pointer_event_t ev;
    if (byte_phase < 3) begin
      pkt_bytes[byte_phase] = b;
      byte_phase++;
      return;
    end
    byte_phase = 0;
    hdr = pkt_bytes[0];
    btn = hdr[2:0];
    pressed = (btn ^ old_buttons) & btn;
    released = (btn ^ old_buttons) & old_buttons;
    old_buttons = btn;
    dx = hdr[4] ? int'(pkt_bytes[1]) - 256 : int'(pkt_bytes[1]);
    dy = hdr[5] ? 256 - int'(pkt_bytes[2]) : -int'(pkt_bytes[2]);
    nib = b[3:0];
    wheel = (nib == ps2wm_pkg::WHEEL_NEG_ONE_NIB) ? -1 : int'(nib);
    if (dx != 0) x_pos = move_axis(x_pos, dx, x_range);
    if (dy != 0) y_pos = move_axis(y_pos, dy, y_range);
    moved = (dx != 0) || (dy != 0);
    n = 0;
    if (touch_mode) begin
      if (btn[0] && moved) begin
        kinds[n] = ps2wm_pkg::EV_TOUCH_MOVE; ids[n] = 2'd0; wheels[n] = 0; n++;
      end
      if (pressed[0]) begin
        kinds[n] = ps2wm_pkg::EV_TOUCH_BEGIN; ids[n] = 2'd0; wheels[n] = 0; n++;
      end
      if (released[0]) begin
        kinds[n] = ps2wm_pkg::EV_TOUCH_END; ids[n] = 2'd0; wheels[n] = 0; n++;
      end
    end else begin
      if (moved) begin
        kinds[n] = ps2wm_pkg::EV_MOVE; ids[n] = 2'd0; wheels[n] = 0; n++;
      end
      if (wheel != 0) begin
        kinds[n] = ps2wm_pkg::EV_WHEEL; ids[n] = 2'd0; wheels[n] = wheel; n++;
      end
      if (pressed != 0) begin
        kinds[n] = ps2wm_pkg::EV_BTN_DOWN; ids[n] = lowest_button(pressed);
        wheels[n] = 0; n++;
      end
      if (released != 0) begin
        kinds[n] = ps2wm_pkg::EV_BTN_UP; ids[n] = lowest_button(released);
        wheels[n] = 0; n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev.kind = kinds[i];
      ev.x = x_pos[CW-1:0];
      ev.y = y_pos[CW-1:0];
      ev.btn = ids[i];
      ev.wheel = wheels[i][4:0];
      ev.last = (i == n - 1);
      pending_events.push_back(ev);
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task check_event(logic [39:0] data, logic last);
    pointer_event_t got;
    pointer_event_t want;
    got.kind = data[2:0];
    got.x = data[14:3];
    got.y = data[26:15];
    got.btn = data[28:27];
    got.wheel = data[33:29];
    got.last = last;
    if (pending_events.size() == 0) begin
      report($sformatf("event kind %0d with none expected", got.kind));
      return;
    end
    want = pending_events.pop_front();
    if (got.kind != want.kind)
      report($sformatf("event_kind %0d, expected %0d", got.kind, want.kind));
    if (got.x != want.x)
      report($sformatf("x_pos %0d, expected %0d", got.x, want.x));
    if (got.y != want.y)
      report($sformatf("y_pos %0d, expected %0d", got.y, want.y));
    if (got.btn != want.btn)
      report($sformatf("button_id %0d, expected %0d", got.btn, want.btn));
    if (got.wheel != want.wheel)
      report($sformatf("wheel_delta %0d, expected %0d", got.wheel, want.wheel));
    if (got.last != want.last)
      report($sformatf("last_of_packet %0d, expected %0d", got.last, want.last));
  endtask
endclass

module testbench;

  localparam int OUT_W       = ((2 * ps2wm_pkg::COORD_WIDTH_DEFAULT + 10 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 12;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [ps2wm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ps2wm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [7:0]                        s_tdata = 8'h00;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [OUT_W-1:0]                  m_tdata;
  logic                              m_tlast;

  tracker_scoreboard board = new();

  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  int hold_request = 0;
  int idle_cycles = 0;

  ps2_wheel_mouse_pointer_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.take_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_event(m_tdata[39:0], m_tlast);
  end

  // Ends the run when neither side has seen a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Event receiver: random stalls, eager stretches, and a long hold on request.
  initial begin
    int r;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        m_tready = 1'b0;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else if (rx_eager) begin
        m_tready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready = 1'b1;
        end else begin
          m_tready = 1'b0;
          if (r < 95) repeat ($urandom_range(0, 3)) @(negedge clk);
          else repeat ($urandom_range(8, 30)) @(negedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called and returns at a falling edge; tvalid stays up between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] hdr, dx, dy, whl);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
    send_byte(whl);
  endtask

  // Zero, small or full-range deltas so that clamping and the no-move case both show up.
  task automatic pick_delta(output logic [7:0] low, output logic sign);
    int r;
    int mag;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      low = 8'h00;
      sign = 1'b0;
    end else if (r == 1) begin
      mag = $urandom_range(1, 8);
      sign = $urandom_range(0, 1);
      low = sign ? 8'(256 - mag) : 8'(mag);
    end else begin
      low = $urandom_range(0, 255);
      sign = $urandom_range(0, 1);
    end
  endtask

  task automatic send_random_packet();
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] whl;
    logic       sx;
    logic       sy;
    hdr = $urandom_range(0, 255);
    pick_delta(dx, sx);
    pick_delta(dy, sy);
    hdr[4] = sx;
    hdr[5] = sy;
    if ($urandom_range(0, 3) != 0) hdr[3] = 1'b1;
    whl = $urandom_range(0, 255);
    if ($urandom_range(0, 2) == 0) whl[3:0] = 4'h0;
    send_packet(hdr, dx, dy, whl);
  endtask

  task automatic apply_config(input logic [12:0] xr, yr, input logic tm);
    cfg_we = 1'b1;
    cfg_index = ps2wm_pkg::CFG_X_RANGE;
    cfg_data = xr;
    board.write_reg(ps2wm_pkg::CFG_X_RANGE, xr);
    @(negedge clk);
    cfg_index = ps2wm_pkg::CFG_Y_RANGE;
    cfg_data = yr;
    board.write_reg(ps2wm_pkg::CFG_Y_RANGE, yr);
    @(negedge clk);
    cfg_index = ps2wm_pkg::CFG_TOUCH_MODE;
    cfg_data = {12'd0, tm};
    board.write_reg(ps2wm_pkg::CFG_TOUCH_MODE, {12'd0, tm});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A packet with no events may still be in flight after the last expected event.
  task automatic drain();
    s_tvalid = 1'b0;
    while (board.pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [12:0] xr_set [6];
    logic [12:0] yr_set [6];
    logic        tm_set [6];
    xr_set = '{13'd640, 13'd4096, 13'd300, 13'd8191, 13'd1, 13'd0};
    yr_set = '{13'd480, 13'd4096, 13'd2000, 13'd0, 13'd1, 13'd0};
    tm_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Mouse mode at reset ranges: every mouse-mode event kind, both signs, wheel -1 and 14.
    rx_eager = 1'b1;
    send_packet(8'h01, 8'h05, 8'h03, 8'h0f);
    send_packet(8'h36, 8'h00, 8'h00, 8'h0e);
    send_packet(8'hff, 8'hff, 8'hff, 8'hf0);
    send_packet(8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    // Touch mode with a zero x range and an oversized y range.
    apply_config(13'd0, 13'd8191, 1'b1);
    rx_eager = 1'b0;
    send_packet(8'h09, 8'h10, 8'h00, 8'h05);
    send_packet(8'h08, 8'h00, 8'h80, 8'h00);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        xr_set[ph] = $urandom_range(0, 8191);
        yr_set[ph] = $urandom_range(0, 8191);
        tm_set[ph] = $urandom_range(0, 1);
      end
      apply_config(xr_set[ph], yr_set[ph], tm_set[ph]);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      if (ph == 1) begin
        // Fill the packet queue behind a stalled receiver.
        tx_eager = 1'b1;
        rx_eager = 1'b0;
        hold_request = 150;
      end
      for (int p = 0; p < 5; p++) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255));
        end
        while (board.byte_phase != 0) send_byte($urandom_range(0, 255));
        send_random_packet();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (board.pending_events.size() != 0)
      board.report($sformatf("%0d expected events never arrived",
                             board.pending_events.size()));
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
